// File: hw/rtl/itt_pkg.sv
// Shared types and constants of the interval timer table.
package itt_pkg;

    // Input function codes
    localparam logic [1:0] FN_SET  = 2'd0;
    localparam logic [1:0] FN_KILL = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    // Result codes
    localparam logic [2:0] RC_SET_OK    = 3'd0;
    localparam logic [2:0] RC_SET_DUP   = 3'd1;
    localparam logic [2:0] RC_SET_FULL  = 3'd2;
    localparam logic [2:0] RC_KILL_OK   = 3'd3;
    localparam logic [2:0] RC_KILL_NONE = 3'd4;
    localparam logic [2:0] RC_FIRED     = 3'd5;

    // Most fired results one tick may produce
    localparam int MAX_FIRES  = 32;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLY,
        ST_FLUSH
    } itt_state_t;

    typedef struct packed {
        logic accept;   // capture input transaction
        logic scan;     // walk the table
        logic reply;    // commit set/kill and emit its result
        logic flush;    // emit held fired result as the last one
    } itt_cmd_t;

    typedef struct packed {
        logic start_scan;  // offered item needs a table walk
        logic scan_done;   // walk finished
        logic op_tick;     // current item is a tick
        logic out_free;    // output register can take a result
        logic pend_valid;  // a fired result is held back
    } itt_status_t;

endpackage

// File: hw/rtl/interval_timer_table.sv
// Top level of the interval timer table: controller plus datapath.
//
// Usage:
//   s_* channel takes one transaction per item: func set (owner, timer id,
//   interval, call count), kill (owner, timer id) or a one millisecond tick.
//   m_* channel returns results; m_last marks the final result of an item.
//   cfg_* channel writes check_period (ms between scans); always ready; it must be
//   written only while the block is idle, which the block does not enforce.
// Table walk:
//   Set, kill and a scanning tick walk the TIMER_SLOTS entries, one per cycle
//   unless stalled, through the single read port of the entry memory; a tick
//   stops early when another entry is due after MAX_FIRES have fired. The
//   final result is registered before the next item is accepted.
//   A tick that does not reach check_period gives no result and no walk.
//   Fired results leave in slot order; one is held back so the last one can
//   carry m_last.
// Reset: aresetn low clears the valid bits and time counters, check_period 1.
//   No clearing pass is needed.
// Stall: a full output register holds the final result and, on a tick, pauses
//   the walk when a fired result must move out; nothing is dropped.
module interval_timer_table
    import itt_pkg::*;
#(
    parameter int TIMER_SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_owner,
    input  logic [31:0] s_timer_id,
    input  logic [31:0] s_interval,
    input  logic [31:0] s_call_times,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_code,
    output logic [15:0] m_owner_res,
    output logic [31:0] m_timer_id_res,
    output logic        m_last
);

    itt_cmd_t    cmd;
    itt_status_t status;

    // the period register takes a write in any cycle
    assign cfg_ready = 1'b1;

    itt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itt_dpath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_func         (s_func),
        .s_owner        (s_owner),
        .s_timer_id     (s_timer_id),
        .s_interval     (s_interval),
        .s_call_times   (s_call_times),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_code  (m_result_code),
        .m_owner_res    (m_owner_res),
        .m_timer_id_res (m_timer_id_res),
        .m_last         (m_last)
    );

endmodule

// File: hw/rtl/itt_ctrl.sv
// Controller state machine of the interval timer table.
module itt_ctrl
    import itt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  itt_status_t status,
    output itt_cmd_t    cmd
);

    itt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.start_scan) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) state_next = status.op_tick ? ST_FLUSH : ST_REPLY;
            end
            ST_REPLY: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_FLUSH: begin
                if (!status.pend_valid || status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_SCAN:  cmd.scan  = 1'b1;
            ST_REPLY: cmd.reply = status.out_free;
            ST_FLUSH: cmd.flush = status.pend_valid && status.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/itt_dpath.sv
// Datapath of the interval timer table: entry memory, clocks, scan and result registers.
module itt_dpath
    import itt_pkg::*;
#(
    parameter int TIMER_SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  itt_cmd_t    cmd,
    output itt_status_t status,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_owner,
    input  logic [31:0] s_timer_id,
    input  logic [31:0] s_interval,
    input  logic [31:0] s_call_times,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_code,
    output logic [15:0] m_owner_res,
    output logic [31:0] m_timer_id_res,
    output logic        m_last
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    // Entry memory, one read and one write port
    logic [15:0] mem_owner [TIMER_SLOTS];
    logic [31:0] mem_id    [TIMER_SLOTS];
    logic [31:0] mem_ivl   [TIMER_SLOTS];
    logic [31:0] mem_rem   [TIMER_SLOTS];
    logic [31:0] mem_lf    [TIMER_SLOTS];

    logic [15:0] rd_owner_reg;
    logic [31:0] rd_id_reg, rd_ivl_reg, rd_rem_reg, rd_lf_reg;

    logic             rd_en, mem_we_key, mem_we_cnt;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wivl, mem_wrem, mem_wlf;

    // Control state
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]            time_now_reg, time_now_next;
    logic [31:0]            last_check_reg, last_check_next;
    logic [15:0]            period_reg, period_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   ev_valid_reg, ev_valid_next;
    logic                   stop_reg, stop_next;
    logic [FIRE_CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic                   match_found_reg, match_found_next;
    logic                   free_found_reg, free_found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload
    logic [IDX_W-1:0] ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [1:0]       op_func_reg, op_func_next;
    logic [15:0]      op_owner_reg, op_owner_next;
    logic [31:0]      op_id_reg, op_id_next;
    logic [31:0]      op_ivl_reg, op_ivl_next;
    logic [31:0]      op_cnt_reg, op_cnt_next;
    logic [15:0]      pend_owner_reg, pend_owner_next;
    logic [31:0]      pend_id_reg, pend_id_next;
    logic [2:0]       out_code_reg, out_code_next;
    logic [15:0]      out_owner_reg, out_owner_next;
    logic [31:0]      out_id_reg, out_id_next;
    logic             out_last_reg, out_last_next;

    logic [31:0] time_inc;
    logic        tick_due, rd_active, out_free, op_tick;
    logic        ev_live, due, capped, stall, key_hit;

    assign time_inc  = time_now_reg + 32'd1;
    assign tick_due  = !((time_inc - last_check_reg) < {16'd0, period_reg});
    assign rd_active = (rd_idx_reg < CNT_W'(TIMER_SLOTS)) && !stop_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign op_tick   = (op_func_reg == FN_TICK);
    assign ev_live   = valid_reg[ev_idx_reg];
    assign due       = ev_live && ((time_now_reg - rd_lf_reg) >= rd_ivl_reg);
    assign capped    = (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRES));
    assign key_hit   = ev_live && (rd_owner_reg == op_owner_reg) && (rd_id_reg == op_id_reg);
    // hold the walk while a second fire waits behind a full output
    assign stall     = ev_valid_reg && op_tick && due && !capped
                       && pend_valid_reg && !out_free;

    assign status.start_scan = (s_func == FN_SET) || (s_func == FN_KILL)
                               || ((s_func == FN_TICK) && tick_due);
    assign status.scan_done  = !rd_active && !ev_valid_reg;
    assign status.op_tick    = op_tick;
    assign status.out_free   = out_free;
    assign status.pend_valid = pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (mem_we_key) begin
            mem_owner[mem_waddr] <= op_owner_reg;
            mem_id[mem_waddr]    <= op_id_reg;
            mem_ivl[mem_waddr]   <= mem_wivl;
        end
        if (mem_we_cnt) begin
            mem_rem[mem_waddr] <= mem_wrem;
            mem_lf[mem_waddr]  <= mem_wlf;
        end
        if (rd_en) begin
            rd_owner_reg <= mem_owner[rd_idx_reg[IDX_W-1:0]];
            rd_id_reg    <= mem_id[rd_idx_reg[IDX_W-1:0]];
            rd_ivl_reg   <= mem_ivl[rd_idx_reg[IDX_W-1:0]];
            rd_rem_reg   <= mem_rem[rd_idx_reg[IDX_W-1:0]];
            rd_lf_reg    <= mem_lf[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        valid_next       = valid_reg;
        time_now_next    = time_now_reg;
        last_check_next  = last_check_reg;
        period_next      = period_reg;
        rd_idx_next      = rd_idx_reg;
        ev_valid_next    = ev_valid_reg;
        stop_next        = stop_reg;
        fire_cnt_next    = fire_cnt_reg;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        pend_valid_next  = pend_valid_reg;
        m_valid_next     = m_valid_reg;
        ev_idx_next      = ev_idx_reg;
        match_idx_next   = match_idx_reg;
        free_idx_next    = free_idx_reg;
        op_func_next     = op_func_reg;
        op_owner_next    = op_owner_reg;
        op_id_next       = op_id_reg;
        op_ivl_next      = op_ivl_reg;
        op_cnt_next      = op_cnt_reg;
        pend_owner_next  = pend_owner_reg;
        pend_id_next     = pend_id_reg;
        out_code_next    = out_code_reg;
        out_owner_next   = out_owner_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        rd_en            = 1'b0;
        mem_we_key       = 1'b0;
        mem_we_cnt       = 1'b0;
        mem_waddr        = ev_idx_reg;
        mem_wivl         = (op_ivl_reg == 32'd0) ? 32'd1 : op_ivl_reg;
        mem_wrem         = rd_rem_reg - 32'd1;
        mem_wlf          = time_now_reg;

        if (m_ready) m_valid_next = 1'b0;
        if (cfg_valid) period_next = cfg_data;

        if (cmd.accept) begin
            op_func_next     = s_func;
            op_owner_next    = s_owner;
            op_id_next       = s_timer_id;
            op_ivl_next      = s_interval;
            op_cnt_next      = s_call_times;
            rd_idx_next      = '0;
            ev_valid_next    = 1'b0;
            stop_next        = 1'b0;
            fire_cnt_next    = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            pend_valid_next  = 1'b0;
            if (s_func == FN_TICK) begin
                time_now_next = time_inc;
                if (tick_due) last_check_next = time_inc;
            end
        end

        if (cmd.scan && !stall) begin
            rd_en         = rd_active;
            ev_valid_next = rd_active;
            ev_idx_next   = rd_idx_reg[IDX_W-1:0];
            if (rd_active) rd_idx_next = rd_idx_reg + CNT_W'(1);
            if (ev_valid_reg) begin
                if (op_tick) begin
                    if (due && capped) begin
                        stop_next     = 1'b1;
                        ev_valid_next = 1'b0;
                    end else if (due) begin
                        // previous fire is now known not to be the last
                        if (pend_valid_reg) begin
                            m_valid_next   = 1'b1;
                            out_code_next  = RC_FIRED;
                            out_owner_next = pend_owner_reg;
                            out_id_next    = pend_id_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_owner_next = rd_owner_reg;
                        pend_id_next    = rd_id_reg;
                        mem_we_cnt      = 1'b1;
                        fire_cnt_next   = fire_cnt_reg + FIRE_CNT_W'(1);
                        if (rd_rem_reg == 32'd1) valid_next[ev_idx_reg] = 1'b0;
                    end
                end else begin
                    if (key_hit && !match_found_reg) begin
                        match_found_next = 1'b1;
                        match_idx_next   = ev_idx_reg;
                    end
                    if (!ev_live && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = ev_idx_reg;
                    end
                end
            end
        end

        if (cmd.reply) begin
            m_valid_next   = 1'b1;
            out_owner_next = op_owner_reg;
            out_id_next    = op_id_reg;
            out_last_next  = 1'b1;
            if (op_func_reg == FN_SET) begin
                if (match_found_reg) begin
                    out_code_next = RC_SET_DUP;
                end else if (free_found_reg) begin
                    out_code_next           = RC_SET_OK;
                    mem_waddr               = free_idx_reg;
                    mem_we_key              = 1'b1;
                    mem_we_cnt              = 1'b1;
                    mem_wrem                = op_cnt_reg;
                    mem_wlf                 = last_check_reg;
                    valid_next[free_idx_reg] = 1'b1;
                end else begin
                    out_code_next = RC_SET_FULL;
                end
            end else begin
                if (match_found_reg) begin
                    out_code_next             = RC_KILL_OK;
                    valid_next[match_idx_reg] = 1'b0;
                end else begin
                    out_code_next = RC_KILL_NONE;
                end
            end
        end

        if (cmd.flush) begin
            m_valid_next    = 1'b1;
            out_code_next   = RC_FIRED;
            out_owner_next  = pend_owner_reg;
            out_id_next     = pend_id_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            time_now_reg    <= '0;
            last_check_reg  <= '0;
            period_reg      <= 16'd1;
            rd_idx_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            stop_reg        <= 1'b0;
            fire_cnt_reg    <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            time_now_reg    <= time_now_next;
            last_check_reg  <= last_check_next;
            period_reg      <= period_next;
            rd_idx_reg      <= rd_idx_next;
            ev_valid_reg    <= ev_valid_next;
            stop_reg        <= stop_next;
            fire_cnt_reg    <= fire_cnt_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg     <= ev_idx_next;
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        op_func_reg    <= op_func_next;
        op_owner_reg   <= op_owner_next;
        op_id_reg      <= op_id_next;
        op_ivl_reg     <= op_ivl_next;
        op_cnt_reg     <= op_cnt_next;
        pend_owner_reg <= pend_owner_next;
        pend_id_reg    <= pend_id_next;
        out_code_reg   <= out_code_next;
        out_owner_reg  <= out_owner_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_code  = out_code_reg;
    assign m_owner_res    = out_owner_reg;
    assign m_timer_id_res = out_id_reg;
    assign m_last         = out_last_reg;

endmodule

// File: hw/rtl/itt_checker.sv
// Port-level assertions for the interval timer table, bound to the top level.
module itt_checker
    import itt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_result_code,
    input logic [15:0] m_owner_res,
    input logic [31:0] m_timer_id_res,
    input logic        m_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_code)
            && $stable(m_owner_res) && $stable(m_timer_id_res) && $stable(m_last))
        else $error("result changed while stalled");

    // set and kill answers are single results
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code != RC_FIRED) |-> m_last)
        else $error("set/kill result without last");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_code <= RC_FIRED))
        else $error("result code out of range");

    // a set or kill always walks the table before the next transaction
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_func == FN_SET) || (s_func == FN_KILL)) |=> !s_ready)
        else $error("input accepted during table walk");

endmodule

bind interval_timer_table itt_checker u_itt_checker (.*);

// File: tb/interval_timer_table_test.sv
// Self-checking testbench for the interval timer table: random and directed set/kill/tick traffic.
module interval_timer_table_test;
    import itt_pkg::*;

    localparam int          SLOTS       = 32;
    localparam int          SETTLE      = SLOTS + 8;  // time for a quiet scanning tick to finish
    localparam int          HOLD_CYCLES = 400;        // long receiver back-pressure
    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [1:0]  FN_RESERVED = 2'd3;       // unused func code, must be ignored

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the timer table, predicts the outcomes of
    // every accepted input transaction and checks them in order.
    // ------------------------------------------------------------------
    class timer_outcome_board;
        typedef struct packed {
            logic [2:0]  code;
            logic [15:0] owner;
            logic [31:0] id;
            logic        last;
        } outcome_t;

        bit          used [SLOTS];
        bit [15:0]   slot_owner [SLOTS];
        bit [31:0]   slot_id [SLOTS];
        bit [31:0]   slot_period [SLOTS];
        bit [31:0]   slot_left [SLOTS];
        bit [31:0]   slot_mark [SLOTS];
        bit [31:0]   now_ms;
        bit [31:0]   scan_mark;
        bit [15:0]   check_period;
        outcome_t    due_outcomes [$];
        int          errors;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            now_ms       = '0;
            scan_mark    = '0;
            check_period = 16'd1;
            errors       = 0;
        endfunction

        function outcome_t make_outcome(logic [2:0] code, logic [15:0] own,
                                        logic [31:0] id, logic last);
            outcome_t o;
            o.code  = code;
            o.owner = own;
            o.id    = id;
            o.last  = last;
            return o;
        endfunction

        function int find_slot(bit [15:0] own, bit [31:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && slot_owner[i] == own && slot_id[i] == id) return i;
            return -1;
        endfunction

        function int random_live_slot();
            int live [$];
            for (int i = 0; i < SLOTS; i++) if (used[i]) live = {live, i};
            if (live.size() == 0) return -1;
            return live[$urandom_range(live.size() - 1)];
        endfunction

        function int pending();
            return due_outcomes.size();
        endfunction

        // Accepted input transaction: update the table, queue what it causes.
        function void note_request(logic [1:0] fn, logic [15:0] own, logic [31:0] id,
                                   logic [31:0] ivl, logic [31:0] cnt);
            outcome_t fired [$];
            int       hit;
            int       free_slot;
            hit       = find_slot(own, id);
            free_slot = -1;
            case (fn)
                FN_SET: begin
                    if (hit >= 0) begin
                        due_outcomes = {due_outcomes, make_outcome(RC_SET_DUP, own, id, 1'b1)};
                        return;
                    end
                    for (int i = 0; i < SLOTS; i++)
                        if (!used[i]) begin
                            free_slot = i;
                            break;
                        end
                    if (free_slot < 0) begin
                        due_outcomes = {due_outcomes, make_outcome(RC_SET_FULL, own, id, 1'b1)};
                        return;
                    end
                    used[free_slot]        = 1'b1;
                    slot_owner[free_slot]  = own;
                    slot_id[free_slot]     = id;
                    slot_period[free_slot] = (ivl == 0) ? 32'd1 : ivl;
                    slot_left[free_slot]   = cnt;
                    slot_mark[free_slot]   = scan_mark;
                    due_outcomes = {due_outcomes, make_outcome(RC_SET_OK, own, id, 1'b1)};
                end
                FN_KILL: begin
                    if (hit >= 0) begin
                        used[hit] = 1'b0;
                        due_outcomes = {due_outcomes, make_outcome(RC_KILL_OK, own, id, 1'b1)};
                    end else begin
                        due_outcomes = {due_outcomes,
                                        make_outcome(RC_KILL_NONE, own, id, 1'b1)};
                    end
                end
                FN_TICK: begin
                    now_ms = now_ms + 32'd1;
                    if (now_ms - scan_mark < {16'h0, check_period}) return;
                    scan_mark = now_ms;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!used[i] || (now_ms - slot_mark[i] < slot_period[i])) continue;
                        if (fired.size() >= MAX_FIRES) break;
                        fired = {fired, make_outcome(RC_FIRED, slot_owner[i], slot_id[i], 1'b0)};
                        slot_mark[i] = now_ms;
                        slot_left[i] = slot_left[i] - 32'd1;  // 0 wraps to all ones
                        if (slot_left[i] == 0) used[i] = 1'b0;
                    end
                    if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
                    due_outcomes = {due_outcomes, fired};
                end
                default: ;  // reserved code: no effect
            endcase
        endfunction

        // Accepted result transaction: compare against the oldest prediction.
        function void check_outcome(logic [2:0] code, logic [15:0] own, logic [31:0] id,
                                    logic last);
            outcome_t want;
            if (due_outcomes.size() == 0) begin
                $error("unexpected result: code %0d owner %0h id %0h last %0b",
                       code, own, id, last);
                errors++;
                return;
            end
            want = due_outcomes.pop_front();
            if (code !== want.code) begin
                $error("m_result_code: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (own !== want.owner) begin
                $error("m_owner_res: expected %0h, actual %0h", want.owner, own);
                errors++;
            end
            if (id !== want.id) begin
                $error("m_timer_id_res: expected %0h, actual %0h", want.id, id);
                errors++;
            end
            if (last !== want.last) begin
                $error("m_last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [15:0] s_owner;
    logic [31:0] s_timer_id;
    logic [31:0] s_interval;
    logic [31:0] s_call_times;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_result_code;
    logic [15:0] m_owner_res;
    logic [31:0] m_timer_id_res;
    logic        m_last;

    timer_outcome_board board;
    int                 src_idle_pct;   // chance the sender inserts a gap
    int                 sink_idle_pct;  // chance the receiver drops ready
    bit                 hold_req;       // asks the receiver for a long stall
    int                 cycle_count;

    interval_timer_table #(.TIMER_SLOTS(SLOTS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_owner       (s_owner),
        .s_timer_id    (s_timer_id),
        .s_interval    (s_interval),
        .s_call_times  (s_call_times),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_code (m_result_code),
        .m_owner_res   (m_owner_res),
        .m_timer_id_res(m_timer_id_res),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: every accepted result transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_outcome(m_result_code, m_owner_res, m_timer_id_res, m_last);
    end

    // Receiver: random ready at the falling edge; a hold request stalls it, so
    // the block backs up and drops s_ready.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // One input transaction. Called and returns at a falling edge; valid stays
    // high between back-to-back items and drops only for a gap.
    task automatic send_item(input logic [1:0] fn, input logic [15:0] own,
                             input logic [31:0] id, input logic [31:0] ivl,
                             input logic [31:0] cnt);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_owner      <= own;
        s_timer_id   <= id;
        s_interval   <= ivl;
        s_call_times <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(fn, own, id, ivl, cnt);
        @(negedge aclk);
    endtask

    // Sender pauses until every predicted result has been seen.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
    endtask

    // check_period write, only with the block quiet: a tick that scans and
    // finds nothing due leaves no result behind, so give it time to finish.
    task automatic write_check_period(input logic [15:0] value);
        pause_until_drained();
        repeat (SETTLE) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.check_period = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Keys come mostly from a small pool so duplicates and kill hits happen.
    function automatic logic [47:0] random_key();
        logic [15:0] own;
        logic [31:0] id;
        case ($urandom_range(9))
            0:       own = 16'($urandom);
            1:       own = 16'hFFFF;
            default: own = 16'($urandom_range(3));
        endcase
        case ($urandom_range(9))
            0:       id = $urandom;
            1:       id = 32'hFFFF_FFFF;
            default: id = $urandom_range(5);
        endcase
        return {own, id};
    endfunction

    // Mixed random traffic; reserved-code items are extra and not counted.
    task automatic random_mix(input int count, input bit pause_midway);
        int          done_n;
        int          pick;
        int          slot;
        logic [47:0] key;
        logic [31:0] ivl;
        logic [31:0] cnt;
        done_n = 0;
        while (done_n < count) begin
            if (pause_midway && done_n == count / 2) pause_until_drained();
            pick = $urandom_range(99);
            key  = random_key();
            case ($urandom_range(9))
                0:          ivl = 32'd0;
                1, 2:       ivl = $urandom_range(7, 40);
                3:          ivl = $urandom;
                default:    ivl = $urandom_range(1, 6);
            endcase
            case ($urandom_range(9))
                0:          cnt = 32'd0;
                1, 2, 3:    cnt = $urandom;
                default:    cnt = $urandom_range(1, 4);
            endcase
            if (pick < 2) begin
                send_item(FN_RESERVED, key[47:32], key[31:0], ivl, cnt);
                continue;
            end
            if (pick < 38) begin
                send_item(FN_SET, key[47:32], key[31:0], ivl, cnt);
            end else if (pick < 62) begin
                slot = board.random_live_slot();
                if (slot >= 0 && $urandom_range(9) < 7)
                    key = {board.slot_owner[slot], board.slot_id[slot]};
                send_item(FN_KILL, key[47:32], key[31:0], ivl, cnt);
            end else begin
                send_item(FN_TICK, key[47:32], key[31:0], ivl, cnt);
            end
            done_n++;
        end
    endtask

    // Fill the table past capacity with short timers (scans are held off by a
    // large check_period), then offer a duplicate of the first one.
    task automatic fill_table();
        logic [15:0] first_own;
        logic [31:0] first_id;
        logic [15:0] own;
        logic [31:0] id;
        first_own = 16'($urandom);
        first_id  = $urandom;
        for (int k = 0; k < SLOTS + 2; k++) begin
            own = (k == 0) ? first_own : 16'($urandom);
            id  = (k == 0) ? first_id : $urandom;
            send_item(FN_SET, own, id, $urandom_range(1, 2),
                      (k % 4 == 0) ? 32'd0 : $urandom_range(1, 3));
            if (k % 8 == 7) send_item(FN_TICK, 16'($urandom), $urandom, $urandom, $urandom);
        end
        send_item(FN_SET, first_own, first_id, 32'd1, 32'd1);
    endtask

    initial begin
        board         = new();
        cycle_count   = 0;
        hold_req      = 1'b0;
        src_idle_pct  = 28;
        sink_idle_pct = 60;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_func        = FN_TICK;
        s_owner       = '0;
        s_timer_id    = '0;
        s_interval    = '0;
        s_call_times  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, check_period 0 (every tick scans).
        write_check_period(16'd0);
        send_item(FN_SET,  16'h0000, 32'h0000_0000, 32'd0, 32'd2);           // zero interval
        send_item(FN_SET,  16'h0000, 32'h0000_0000, 32'd5, 32'd5);           // duplicate
        send_item(FN_SET,  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_SET,  16'h0000, 32'hFFFF_FFFF, 32'd2, 32'd0);           // count wraps
        send_item(FN_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_TICK, 16'h0, 32'h0, 32'h0, 32'h0);                      // one fires
        send_item(FN_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_TICK, 16'h0, 32'h0, 32'h0, 32'h0);                      // scan, none due
        send_item(FN_KILL, 16'h0000, 32'h0000_0000, 32'd0, 32'd0);           // expired: none
        send_item(FN_KILL, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(FN_KILL, 16'h0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(FN_KILL, 16'h1234, $urandom, 32'd0, 32'd0);
        send_item(FN_SET,  16'h0005, 32'h0000_0007, 32'd3, 32'd1);
        send_item(FN_SET,  16'h0005, 32'h0000_0008, 32'd1, 32'd1);
        send_item(FN_SET,  16'h0006, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        repeat (4) send_item(FN_TICK, 16'($urandom), $urandom, $urandom, $urandom);
        send_item(FN_KILL, 16'h0006, 32'h8000_0000, 32'd0, 32'd0);
        send_item(FN_KILL, 16'h0006, 32'h8000_0000, 32'd0, 32'd0);           // already gone

        // Random traffic under several check periods and idle profiles.
        write_check_period(16'd1);
        random_mix(120, 1'b1);

        src_idle_pct  = 60;
        sink_idle_pct = 28;
        write_check_period(16'd3);                                           // ticks without scan
        random_mix(80, 1'b0);

        write_check_period(16'hFFFF);
        fill_table();

        // First tick after this fires a full table at once; the receiver is
        // also stalled for a long stretch while items keep coming.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_check_period(16'd1);
        hold_req = 1'b1;
        random_mix(120, 1'b0);

        write_check_period(16'($urandom_range(2, 6)));
        random_mix(60, 1'b0);

        pause_until_drained();
        repeat (SETTLE) @(negedge aclk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
